@@ src/stm_pkg.sv @@
// ----------------------------------------------------------------------------
// stm_pkg
// Shared widths, mode codes, histogram edges and pipeline structs for the
// step timing monitor.
// ----------------------------------------------------------------------------
package stm_pkg;

    localparam int STAT_W      = 32;
    localparam int CNT_W       = 16;
    localparam int PER_W       = 17;
    localparam int MODE_W      = 3;
    localparam int NUM_BUCKETS = 8;
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int NUM_EDGES   = NUM_BUCKETS - 1;
    localparam int PROD_W      = STAT_W + PER_W;

    localparam logic [PER_W-1:0] PERIOD_RESET = PER_W'(10000);

    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POLL  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DONE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

    localparam logic [STAT_W-1:0] BKT_EDGE [NUM_EDGES] = '{
        STAT_W'(100), STAT_W'(250), STAT_W'(500), STAT_W'(1000),
        STAT_W'(2000), STAT_W'(4000), STAT_W'(8000)
    };

    // first bucket whose upper edge holds the value, last bucket otherwise
    function automatic logic [BKT_W-1:0] bucket_of(input logic [STAT_W-1:0] v);
        logic [BKT_W-1:0] b;
        b = BKT_W'(NUM_BUCKETS - 1);
        for (int i = NUM_EDGES - 1; i >= 0; i--) begin
            if (v <= BKT_EDGE[i]) begin
                b = BKT_W'(i);
            end
        end
        return b;
    endfunction

    typedef struct packed {
        logic              valid;
        logic [MODE_W-1:0] mode;
        logic [CNT_W-1:0]  cnt;
        logic [CNT_W-1:0]  sub_cnt;
        logic [STAT_W-1:0] prod;
        logic              due;
        logic [STAT_W-1:0] overrun;
        logic [BKT_W-1:0]  bidx;
    } t_s2;

    typedef struct packed {
        logic              step_due;
        logic [STAT_W-1:0] overrun_total;
        logic [STAT_W-1:0] step_time;
        logic [STAT_W-1:0] lateness;
        logic [STAT_W-1:0] step_min;
        logic [STAT_W-1:0] step_max;
        logic [STAT_W-1:0] lat_min;
        logic [STAT_W-1:0] lat_max;
        logic [STAT_W-1:0] sample_count;
        logic [STAT_W-1:0] step_sum;
        logic [STAT_W-1:0] lat_sum;
        logic [STAT_W-1:0] bucket_value;
    } t_res;

endpackage

@@ src/stm_if.sv @@
// ----------------------------------------------------------------------------
// stm_if
// Valid/ready channel interfaces for event input and result output.
// ----------------------------------------------------------------------------
interface stm_in_if;
    logic                              valid;
    logic                              ready;
    logic [stm_pkg::MODE_W-1:0]        mode;
    logic [stm_pkg::CNT_W-1:0]         timer_count;
    logic [stm_pkg::BKT_W-1:0]         bucket_index;

    modport source (output valid, mode, timer_count, bucket_index, input ready);
    modport sink   (input valid, mode, timer_count, bucket_index, output ready);
endinterface

interface stm_out_if;
    logic                              valid;
    logic                              ready;
    logic                              step_due;
    logic [stm_pkg::STAT_W-1:0]        overrun_total;
    logic [stm_pkg::STAT_W-1:0]        step_time;
    logic [stm_pkg::STAT_W-1:0]        lateness;
    logic [stm_pkg::STAT_W-1:0]        step_min;
    logic [stm_pkg::STAT_W-1:0]        step_max;
    logic [stm_pkg::STAT_W-1:0]        lat_min;
    logic [stm_pkg::STAT_W-1:0]        lat_max;
    logic [stm_pkg::STAT_W-1:0]        sample_count;
    logic [stm_pkg::STAT_W-1:0]        step_sum;
    logic [stm_pkg::STAT_W-1:0]        lat_sum;
    logic [stm_pkg::STAT_W-1:0]        bucket_value;

    modport source (
        output valid, step_due, overrun_total, step_time, lateness, step_min,
               step_max, lat_min, lat_max, sample_count, step_sum, lat_sum,
               bucket_value,
        input  ready
    );
    modport sink (
        input  valid, step_due, overrun_total, step_time, lateness, step_min,
               step_max, lat_min, lat_max, sample_count, step_sum, lat_sum,
               bucket_value,
        output ready
    );
endinterface

@@ src/stm_ram.sv @@
// ----------------------------------------------------------------------------
// stm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module stm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/stm_sched.sv @@
// ----------------------------------------------------------------------------
// stm_sched
// Tick bookkeeping stage: tick count, serviced tick, step start and overrun
// total, plus the period multiply for lateness and step duration.
// ----------------------------------------------------------------------------
module stm_sched (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_acc,
    input  logic [stm_pkg::MODE_W-1:0]  i_mode,
    input  logic [stm_pkg::CNT_W-1:0]   i_cnt,
    input  logic [stm_pkg::BKT_W-1:0]   i_bidx,
    input  logic [stm_pkg::PER_W-1:0]   i_period,
    output stm_pkg::t_s2                o_s2
);

    logic [stm_pkg::STAT_W-1:0] r_tick, n_tick;
    logic [stm_pkg::STAT_W-1:0] r_serv, n_serv;
    logic [stm_pkg::STAT_W-1:0] r_stick, n_stick;
    logic [stm_pkg::CNT_W-1:0]  r_scnt, n_scnt;
    logic [stm_pkg::STAT_W-1:0] r_over, n_over;
    stm_pkg::t_s2               r_s2, n_s2;

    logic                       due;
    logic [stm_pkg::STAT_W-1:0] skipped;
    logic [stm_pkg::STAT_W-1:0] span;
    logic [stm_pkg::STAT_W-1:0] mult_a;
    logic [stm_pkg::PROD_W-1:0] prod;

    always_comb begin
        due     = (i_mode == stm_pkg::MODE_POLL) && (r_tick != r_serv);
        skipped = r_tick - r_serv - stm_pkg::STAT_W'(1);
        span    = r_tick - r_stick;
        mult_a  = (i_mode == stm_pkg::MODE_POLL) ? skipped : span;
        prod    = stm_pkg::PROD_W'(mult_a) * stm_pkg::PROD_W'(i_period);

        n_tick  = r_tick;
        n_serv  = r_serv;
        n_stick = r_stick;
        n_scnt  = r_scnt;
        n_over  = r_over;
        case (i_mode)
            stm_pkg::MODE_TICK: begin
                n_tick = r_tick + stm_pkg::STAT_W'(1);
            end
            stm_pkg::MODE_POLL: begin
                if (due) begin
                    n_over  = r_over + skipped;
                    n_serv  = r_tick;
                    n_stick = r_tick;
                    n_scnt  = i_cnt;
                end
            end
            stm_pkg::MODE_CLEAR: begin
                n_over = '0;
            end
            default: begin
            end
        endcase

        n_s2.valid   = i_acc;
        n_s2.mode    = i_mode;
        n_s2.cnt     = i_cnt;
        n_s2.sub_cnt = (i_mode == stm_pkg::MODE_DONE) ? r_scnt : '0;
        n_s2.prod    = prod[stm_pkg::STAT_W-1:0];
        n_s2.due     = due;
        n_s2.overrun = n_over;
        n_s2.bidx    = i_bidx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_serv  <= '0;
            r_stick <= '0;
            r_scnt  <= '0;
            r_over  <= '0;
            r_s2.valid <= 1'b0;
        end else begin
            if (i_acc) begin
                r_tick  <= n_tick;
                r_serv  <= n_serv;
                r_stick <= n_stick;
                r_scnt  <= n_scnt;
                r_over  <= n_over;
            end
            if (i_adv) begin
                r_s2 <= n_s2;
            end
        end
    end

    assign o_s2 = r_s2;

endmodule

@@ src/stm_stats.sv @@
// ----------------------------------------------------------------------------
// stm_stats
// Duration and lateness statistics with the histogram held in RAM:
// bucket lookup and read, read-modify-write with forwarding, result stage.
// ----------------------------------------------------------------------------
module stm_stats (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  stm_pkg::t_s2   i_s2,
    output logic           o_valid,
    output stm_pkg::t_res  o_res
);

    // stage 3 item
    logic                        r3_valid;
    logic [stm_pkg::MODE_W-1:0]  r3_mode;
    logic [stm_pkg::STAT_W-1:0]  r3_val;
    logic [stm_pkg::BKT_W-1:0]   r3_bkt;
    logic                        r3_due;
    logic [stm_pkg::STAT_W-1:0]  r3_over;
    logic [stm_pkg::BKT_W-1:0]   r3_bidx;

    // statistics state
    logic [stm_pkg::STAT_W-1:0]  r_late, n_late;
    logic [stm_pkg::STAT_W-1:0]  r_last, n_last;
    logic [stm_pkg::STAT_W-1:0]  r_mm [4];
    logic [stm_pkg::STAT_W-1:0]  n_mm [4];
    logic [stm_pkg::STAT_W-1:0]  r_samp, n_samp;
    logic [stm_pkg::STAT_W-1:0]  r_ssum, n_ssum;
    logic [stm_pkg::STAT_W-1:0]  r_lsum, n_lsum;
    logic [stm_pkg::NUM_BUCKETS-1:0] r_hv, n_hv;

    // last histogram write, for forwarding
    logic                        r_fwe;
    logic [stm_pkg::BKT_W-1:0]   r_fwa;
    logic [stm_pkg::STAT_W-1:0]  r_fwd;

    // result stage
    logic                        r4_valid;
    stm_pkg::t_res               r4_res;
    logic                        r4_fwd;
    logic                        r4_hv;
    logic [stm_pkg::STAT_W-1:0]  r4_wd;

    logic [stm_pkg::STAT_W-1:0]  val2;
    logic [stm_pkg::BKT_W-1:0]   bkt2;
    logic [stm_pkg::STAT_W-1:0]  rd_upd;
    logic [stm_pkg::STAT_W-1:0]  rd_out;
    logic                        done3;
    logic                        clr3;
    logic                        poll3;
    logic [stm_pkg::STAT_W-1:0]  hbase;
    logic [stm_pkg::STAT_W-1:0]  hwd;
    logic                        hwe;
    logic                        first;

    // stage 2: duration or lateness value and its bucket
    always_comb begin
        val2 = i_s2.prod + stm_pkg::STAT_W'(i_s2.cnt) - stm_pkg::STAT_W'(i_s2.sub_cnt);
        bkt2 = stm_pkg::bucket_of(val2);
    end

    stm_ram #(
        .WIDTH (stm_pkg::STAT_W),
        .DEPTH (stm_pkg::NUM_BUCKETS)
    ) u_hist_upd (
        .i_clk   (i_clk),
        .i_we    (hwe),
        .i_waddr (r3_bkt),
        .i_wdata (hwd),
        .i_re    (i_adv),
        .i_raddr (bkt2),
        .o_rdata (rd_upd)
    );

    stm_ram #(
        .WIDTH (stm_pkg::STAT_W),
        .DEPTH (stm_pkg::NUM_BUCKETS)
    ) u_hist_out (
        .i_clk   (i_clk),
        .i_we    (hwe),
        .i_waddr (r3_bkt),
        .i_wdata (hwd),
        .i_re    (i_adv),
        .i_raddr (r3_bidx),
        .o_rdata (rd_out)
    );

    // stage 3: statistics update
    always_comb begin
        done3 = r3_valid && (r3_mode == stm_pkg::MODE_DONE);
        clr3  = r3_valid && (r3_mode == stm_pkg::MODE_CLEAR);
        poll3 = r3_valid && (r3_mode == stm_pkg::MODE_POLL) && r3_due;
        first = (r_samp == '0);

        if (r_fwe && (r_fwa == r3_bkt)) begin
            hbase = r_fwd;
        end else if (r_hv[r3_bkt]) begin
            hbase = rd_upd;
        end else begin
            hbase = '0;
        end
        hwd = hbase + stm_pkg::STAT_W'(1);
        hwe = i_adv && done3;

        n_late = r_late;
        n_last = r_last;
        n_mm   = r_mm;
        n_samp = r_samp;
        n_ssum = r_ssum;
        n_lsum = r_lsum;
        n_hv   = r_hv;

        if (poll3) begin
            n_late = r3_val;
        end
        if (done3) begin
            if (first) begin
                n_mm[0] = r3_val;
                n_mm[1] = r3_val;
                n_mm[2] = r_late;
                n_mm[3] = r_late;
            end else begin
                if (r3_val < r_mm[0]) n_mm[0] = r3_val;
                if (r3_val > r_mm[1]) n_mm[1] = r3_val;
                if (r_late < r_mm[2]) n_mm[2] = r_late;
                if (r_late > r_mm[3]) n_mm[3] = r_late;
            end
            n_last       = r3_val;
            n_ssum       = r_ssum + r3_val;
            n_lsum       = r_lsum + r_late;
            n_samp       = r_samp + stm_pkg::STAT_W'(1);
            n_hv[r3_bkt] = 1'b1;
        end
        if (clr3) begin
            for (int i = 0; i < 4; i++) begin
                n_mm[i] = '0;
            end
            n_samp = '0;
            n_ssum = '0;
            n_lsum = '0;
            n_hv   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r_late   <= '0;
            r_last   <= '0;
            for (int i = 0; i < 4; i++) begin
                r_mm[i] <= '0;
            end
            r_samp   <= '0;
            r_ssum   <= '0;
            r_lsum   <= '0;
            r_hv     <= '0;
            r_fwe    <= 1'b0;
        end else if (i_adv) begin
            r3_valid <= i_s2.valid;
            r4_valid <= r3_valid;
            r_late   <= n_late;
            r_last   <= n_last;
            r_mm     <= n_mm;
            r_samp   <= n_samp;
            r_ssum   <= n_ssum;
            r_lsum   <= n_lsum;
            r_hv     <= n_hv;
            r_fwe    <= hwe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_mode <= i_s2.mode;
            r3_val  <= val2;
            r3_bkt  <= bkt2;
            r3_due  <= i_s2.due;
            r3_over <= i_s2.overrun;
            r3_bidx <= i_s2.bidx;

            r_fwa   <= r3_bkt;
            r_fwd   <= hwd;

            r4_res.step_due      <= r3_due && (r3_mode == stm_pkg::MODE_POLL);
            r4_res.overrun_total <= r3_over;
            r4_res.step_time     <= n_last;
            r4_res.lateness      <= n_late;
            r4_res.step_min      <= n_mm[0];
            r4_res.step_max      <= n_mm[1];
            r4_res.lat_min       <= n_mm[2];
            r4_res.lat_max       <= n_mm[3];
            r4_res.sample_count  <= n_samp;
            r4_res.step_sum      <= n_ssum;
            r4_res.lat_sum       <= n_lsum;
            r4_res.bucket_value  <= '0;
            r4_fwd               <= hwe && (r3_bkt == r3_bidx);
            r4_wd                <= hwd;
            r4_hv                <= n_hv[r3_bidx];
        end
    end

    // bucket count after this item's own update
    always_comb begin
        o_res = r4_res;
        if (r4_fwd) begin
            o_res.bucket_value = r4_wd;
        end else if (r4_hv) begin
            o_res.bucket_value = rd_out;
        end else begin
            o_res.bucket_value = '0;
        end
    end

    assign o_valid = r4_valid;

    a_clear_zeroes_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && clr3) |=> (r_samp == '0))
        else $error("sample count not cleared");

    a_step_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_samp != '0) |-> (r_mm[0] <= r_mm[1]))
        else $error("step min above step max");

    a_lat_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_samp != '0) |-> (r_mm[2] <= r_mm[3]))
        else $error("lateness min above lateness max");

    a_hist_write_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hwe |-> (r3_valid && (r3_mode == stm_pkg::MODE_DONE)))
        else $error("histogram written outside step done");

endmodule

@@ src/step_timing_monitor.sv @@
// ----------------------------------------------------------------------------
// step_timing_monitor
// Run-latest step scheduler and step timing monitor.
// Pipeline: stm_sched register, stage 3, result stage. Throughput: one transfer
// per cycle unless the output stalls; the histogram read-modify-write in RAM
// forwards the previous write, so back-to-back steps into one bucket hold rate.
// Reset: synchronous; clears all statistics and tick state, period to 10000;
// histogram entries are cleared through valid bits at once, no clearing pass.
// ----------------------------------------------------------------------------
module step_timing_monitor (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [stm_pkg::PER_W-1:0]  i_cfg_wdata,
    stm_in_if.sink                     i_in,
    stm_out_if.source                  o_out
);

    logic [stm_pkg::PER_W-1:0] r_period;
    logic                      adv;
    logic                      acc;
    logic                      res_valid;
    stm_pkg::t_s2              s2;
    stm_pkg::t_res             res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= stm_pkg::PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    // the whole pipe moves unless a result is held back
    assign adv        = !res_valid || o_out.ready;
    assign acc        = i_in.valid && adv;
    assign i_in.ready = adv;

    stm_sched u_sched (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_acc    (acc),
        .i_mode   (i_in.mode),
        .i_cnt    (i_in.timer_count),
        .i_bidx   (i_in.bucket_index),
        .i_period (r_period),
        .o_s2     (s2)
    );

    stm_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_s2    (s2),
        .o_valid (res_valid),
        .o_res   (res)
    );

    assign o_out.valid         = res_valid;
    assign o_out.step_due      = res.step_due;
    assign o_out.overrun_total = res.overrun_total;
    assign o_out.step_time     = res.step_time;
    assign o_out.lateness      = res.lateness;
    assign o_out.step_min      = res.step_min;
    assign o_out.step_max      = res.step_max;
    assign o_out.lat_min       = res.lat_min;
    assign o_out.lat_max       = res.lat_max;
    assign o_out.sample_count  = res.sample_count;
    assign o_out.step_sum      = res.step_sum;
    assign o_out.lat_sum       = res.lat_sum;
    assign o_out.bucket_value  = res.bucket_value;

endmodule

@@ verif/tb_step_timing_monitor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_step_timing_monitor
// Self-checking bench for the step timing monitor. Event transfers come from
// a queue through a clocked driver with random gaps; a clocked monitor with
// random stalls compares every result transfer field by field with the
// report predicted at input acceptance. The run covers directed edge cases,
// then random tick/poll/done steps with read, clear and unused modes under
// several period settings, including a long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_step_timing_monitor;

    localparam logic [stm_pkg::MODE_W-1:0] MODE_LAST = 3'd7;
    localparam int NUM_PHASES = 7;
    localparam int PHASE_ITEMS = 118;
    localparam int HOLD_CYCLES = 300;
    localparam logic [stm_pkg::STAT_W-1:0] EDGE_LIMIT [stm_pkg::NUM_BUCKETS-1] = '{
        32'd100, 32'd250, 32'd500, 32'd1000, 32'd2000, 32'd4000, 32'd8000
    };
    localparam int SRC_GAP_TAB [NUM_PHASES] = '{9, 0, 0, 9, 3, 0, 9};
    localparam int SNK_GAP_TAB [NUM_PHASES] = '{9, 0, 0, 0, 9, 9, 3};

    typedef struct packed {
        logic [stm_pkg::MODE_W-1:0] mode;
        logic [stm_pkg::CNT_W-1:0]  cnt;
        logic [stm_pkg::BKT_W-1:0]  bidx;
    } t_event;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [stm_pkg::PER_W-1:0] i_cfg_wdata = '0;

    stm_in_if  in_if ();
    stm_out_if out_if ();

    step_timing_monitor u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #5 i_clk = ~i_clk;

    t_event        event_q [$];
    stm_pkg::t_res report_q [$];
    int            pushed = 0;
    int            errors = 0;
    int            src_wait = 0;
    int            snk_wait = 0;
    int            src_gap_max = 0;
    int            snk_gap_max = 0;
    logic          press_go = 1'b0;
    logic          hold_out = 1'b0;

    // predicted block state
    logic [stm_pkg::PER_W-1:0]  period_m = stm_pkg::PERIOD_RESET;
    logic [stm_pkg::STAT_W-1:0] ticks_m = '0;
    logic [stm_pkg::STAT_W-1:0] serviced_m = '0;
    logic [stm_pkg::STAT_W-1:0] start_tick_m = '0;
    logic [stm_pkg::CNT_W-1:0]  start_cnt_m = '0;
    logic [stm_pkg::STAT_W-1:0] late_m = '0;
    logic [stm_pkg::STAT_W-1:0] overrun_m = '0;
    logic [stm_pkg::STAT_W-1:0] last_m = '0;
    logic [stm_pkg::STAT_W-1:0] step_lo = '0;
    logic [stm_pkg::STAT_W-1:0] step_hi = '0;
    logic [stm_pkg::STAT_W-1:0] late_lo = '0;
    logic [stm_pkg::STAT_W-1:0] late_hi = '0;
    logic [stm_pkg::STAT_W-1:0] samples_m = '0;
    logic [stm_pkg::STAT_W-1:0] step_total = '0;
    logic [stm_pkg::STAT_W-1:0] late_total = '0;
    logic [stm_pkg::STAT_W-1:0] hist_m [stm_pkg::NUM_BUCKETS] = '{default: '0};

    function automatic void clear_stats_m();
        overrun_m = '0;
        samples_m = '0;
        step_total = '0;
        late_total = '0;
        step_lo = '0;
        step_hi = '0;
        late_lo = '0;
        late_hi = '0;
        for (int b = 0; b < stm_pkg::NUM_BUCKETS; b++) hist_m[b] = '0;
    endfunction

    function automatic stm_pkg::t_res advance_monitor(input t_event ev);
        stm_pkg::t_res              r;
        logic [63:0]                wide;
        logic [stm_pkg::STAT_W-1:0] skipped;
        logic [stm_pkg::STAT_W-1:0] dur;
        int                         b;
        r = '0;
        case (ev.mode)
            stm_pkg::MODE_TICK: begin
                ticks_m = ticks_m + 1;
            end
            stm_pkg::MODE_POLL: begin
                if (ticks_m != serviced_m) begin
                    skipped = ticks_m - serviced_m - 1;
                    overrun_m = overrun_m + skipped;
                    serviced_m = ticks_m;
                    start_tick_m = ticks_m;
                    start_cnt_m = ev.cnt;
                    wide = 64'(skipped) * 64'(period_m) + 64'(ev.cnt);
                    late_m = wide[stm_pkg::STAT_W-1:0];
                    r.step_due = 1'b1;
                end
            end
            stm_pkg::MODE_DONE: begin
                wide = 64'(ticks_m - start_tick_m) * 64'(period_m)
                     + 64'(ev.cnt) - 64'(start_cnt_m);
                dur = wide[stm_pkg::STAT_W-1:0];
                if (samples_m == 0) begin
                    step_lo = dur;
                    step_hi = dur;
                    late_lo = late_m;
                    late_hi = late_m;
                end else begin
                    if (dur < step_lo) step_lo = dur;
                    if (dur > step_hi) step_hi = dur;
                    if (late_m < late_lo) late_lo = late_m;
                    if (late_m > late_hi) late_hi = late_m;
                end
                last_m = dur;
                step_total = step_total + dur;
                late_total = late_total + late_m;
                samples_m = samples_m + 1;
                b = stm_pkg::NUM_BUCKETS - 1;
                for (int i = stm_pkg::NUM_BUCKETS - 2; i >= 0; i--) begin
                    if (dur <= EDGE_LIMIT[i]) b = i;
                end
                hist_m[b] = hist_m[b] + 1;
            end
            stm_pkg::MODE_CLEAR: begin
                clear_stats_m();
            end
            default: ;
        endcase
        r.overrun_total = overrun_m;
        r.step_time     = last_m;
        r.lateness      = late_m;
        r.step_min      = step_lo;
        r.step_max      = step_hi;
        r.lat_min       = late_lo;
        r.lat_max       = late_hi;
        r.sample_count  = samples_m;
        r.step_sum      = step_total;
        r.lat_sum       = late_total;
        r.bucket_value  = hist_m[ev.bidx];
        return r;
    endfunction

    task automatic report_field(input string name,
                                input logic [stm_pkg::STAT_W-1:0] want,
                                input logic [stm_pkg::STAT_W-1:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // driver
    always @(posedge i_clk) begin : drive_events
        t_event ev;
        if (!i_rst_n) begin
            in_if.valid        <= 1'b0;
            in_if.mode         <= stm_pkg::MODE_TICK;
            in_if.timer_count  <= '0;
            in_if.bucket_index <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                ev.mode = in_if.mode;
                ev.cnt  = in_if.timer_count;
                ev.bidx = in_if.bucket_index;
                report_q.push_back(advance_monitor(ev));
            end
            if (!in_if.valid || in_if.ready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    in_if.valid <= 1'b0;
                end else if (event_q.size() > 0) begin
                    ev = event_q.pop_front();
                    in_if.mode         <= ev.mode;
                    in_if.timer_count  <= ev.cnt;
                    in_if.bucket_index <= ev.bidx;
                    in_if.valid        <= 1'b1;
                    src_wait = $urandom_range(0, src_gap_max);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : check_reports
        stm_pkg::t_res want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (report_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("result transfer with nothing expected");
                end else begin
                    want = report_q.pop_front();
                    report_field("step_due", 32'(want.step_due), 32'(out_if.step_due));
                    report_field("overrun_total", want.overrun_total, out_if.overrun_total);
                    report_field("step_time", want.step_time, out_if.step_time);
                    report_field("lateness", want.lateness, out_if.lateness);
                    report_field("step_min", want.step_min, out_if.step_min);
                    report_field("step_max", want.step_max, out_if.step_max);
                    report_field("lat_min", want.lat_min, out_if.lat_min);
                    report_field("lat_max", want.lat_max, out_if.lat_max);
                    report_field("sample_count", want.sample_count, out_if.sample_count);
                    report_field("step_sum", want.step_sum, out_if.step_sum);
                    report_field("lat_sum", want.lat_sum, out_if.lat_sum);
                    report_field("bucket_value", want.bucket_value, out_if.bucket_value);
                end
                snk_wait = $urandom_range(0, snk_gap_max);
            end
            if (hold_out || snk_wait > 0) begin
                out_if.ready <= 1'b0;
                if (!hold_out) snk_wait--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // long output hold-off while the sender keeps going
    initial begin : backpressure
        wait (press_go);
        @(posedge i_clk);
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_out <= 1'b0;
    end

    task automatic push(input logic [stm_pkg::MODE_W-1:0] mode,
                        input logic [stm_pkg::CNT_W-1:0] cnt,
                        input logic [stm_pkg::BKT_W-1:0] bidx);
        t_event ev;
        ev.mode = mode;
        ev.cnt  = cnt;
        ev.bidx = bidx;
        event_q.push_back(ev);
        pushed++;
    endtask

    function automatic logic [stm_pkg::BKT_W-1:0] any_bucket();
        return stm_pkg::BKT_W'($urandom_range(0, stm_pkg::NUM_BUCKETS - 1));
    endfunction

    task automatic queue_phase(input int n);
        int                        base;
        int                        pick;
        int                        k;
        logic [stm_pkg::CNT_W-1:0] t0;
        base = pushed;
        while (pushed - base < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                // well-formed step: ticks, poll, maybe more ticks, done
                k = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(0, 4);
                repeat (k) push(stm_pkg::MODE_TICK, stm_pkg::CNT_W'($urandom), any_bucket());
                t0 = stm_pkg::CNT_W'($urandom);
                push(stm_pkg::MODE_POLL, t0, any_bucket());
                k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
                repeat (k) push(stm_pkg::MODE_TICK, stm_pkg::CNT_W'($urandom), any_bucket());
                if ($urandom_range(0, 3) == 0)
                    push(stm_pkg::MODE_DONE, stm_pkg::CNT_W'($urandom), any_bucket());
                else
                    push(stm_pkg::MODE_DONE, t0 + stm_pkg::CNT_W'($urandom_range(0, 9000)),
                         any_bucket());
            end else if (pick < 85) begin
                push(stm_pkg::MODE_READ, stm_pkg::CNT_W'($urandom), any_bucket());
            end else if (pick < 88) begin
                push(stm_pkg::MODE_CLEAR, stm_pkg::CNT_W'($urandom), any_bucket());
            end else if (pick < 94) begin
                push(stm_pkg::MODE_W'($urandom_range(stm_pkg::MODE_READ + 1, MODE_LAST)),
                     stm_pkg::CNT_W'($urandom), any_bucket());
            end else begin
                push(stm_pkg::MODE_W'($urandom_range(stm_pkg::MODE_TICK, stm_pkg::MODE_DONE)),
                     stm_pkg::CNT_W'($urandom), any_bucket());
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (event_q.size() != 0 || in_if.valid || report_q.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_period(input logic [stm_pkg::PER_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        period_m = v;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [stm_pkg::PER_W-1:0] per;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset period, done before any poll, unused modes, poll with no tick
        push(stm_pkg::MODE_DONE, '0, '0);
        push(stm_pkg::MODE_POLL, '1, stm_pkg::BKT_W'(stm_pkg::NUM_BUCKETS - 1));
        push(stm_pkg::MODE_READ + 3'd1, '1, any_bucket());
        push(stm_pkg::MODE_READ + 3'd2, '0, any_bucket());
        push(MODE_LAST, '1, any_bucket());
        push(stm_pkg::MODE_TICK, '1, any_bucket());
        push(stm_pkg::MODE_POLL, '1, any_bucket());
        // skipped ticks count as overrun
        repeat (3) push(stm_pkg::MODE_TICK, '0, any_bucket());
        push(stm_pkg::MODE_POLL, '0, any_bucket());
        // durations on and just past the bucket edges
        push(stm_pkg::MODE_DONE, 16'd100, 3'd0);
        push(stm_pkg::MODE_DONE, 16'd101, 3'd1);
        push(stm_pkg::MODE_DONE, 16'd250, 3'd1);
        push(stm_pkg::MODE_DONE, 16'd1000, 3'd3);
        push(stm_pkg::MODE_DONE, 16'd4000, 3'd5);
        push(stm_pkg::MODE_DONE, 16'd8000, 3'd6);
        push(stm_pkg::MODE_DONE, 16'd8001, 3'd7);
        push(stm_pkg::MODE_POLL, '0, any_bucket());
        // done count below start count wraps to a huge duration
        push(stm_pkg::MODE_TICK, '0, any_bucket());
        push(stm_pkg::MODE_POLL, 16'd200, any_bucket());
        push(stm_pkg::MODE_DONE, '0, 3'd7);
        push(stm_pkg::MODE_READ, '0, '0);
        push(stm_pkg::MODE_READ, '1, stm_pkg::BKT_W'(stm_pkg::NUM_BUCKETS - 1));
        // first sample after clear reloads the extremes
        push(stm_pkg::MODE_CLEAR, '0, any_bucket());
        push(stm_pkg::MODE_DONE, 16'd300, 3'd2);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                1: per = stm_pkg::PER_W'(1);
                2: per = stm_pkg::PER_W'(65536);
                3: per = '0;
                4: per = '1;
                5: per = stm_pkg::PER_W'($urandom_range(1, 65536));
                default: per = stm_pkg::PER_W'($urandom);
            endcase
            if (p > 0) write_period(per);
            src_gap_max = SRC_GAP_TAB[p];
            snk_gap_max = SNK_GAP_TAB[p];
            if (p == 2) press_go = 1'b1;
            queue_phase(PHASE_ITEMS);
            wait_idle();
        end

        if (errors == 0 && report_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
